>>> hdl/bct_pkg.sv
// Shared types and codes for the byte table with valid bits.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bct_pkg;

   typedef enum logic [2:0] {
      OP_READ    = 3'd0,
      OP_WRITE   = 3'd1,
      OP_APPEND  = 3'd2,
      OP_POP     = 3'd3,
      OP_REMOVE  = 3'd4,
      OP_REPLACE = 3'd5,
      OP_FIND    = 3'd6,
      OP_NOP     = 3'd7
   } op_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_RANGE   = 3'd1;
   localparam logic [2:0] ST_MISS    = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_NOVALID = 3'd4;

   localparam logic [1:0] CSR_ENTRIES   = 2'd0;
   localparam logic [1:0] CSR_EMPTY     = 2'd1;
   localparam logic [1:0] CSR_USE_VALID = 2'd2;

   // One stored word: valid flag plus the byte.
   typedef struct packed {
      logic       vld;
      logic [7:0] val;
   } entry_type;

endpackage

>>> hdl/bct_ram.sv
// Single-port table memory, read-first, registered read data.
// Depends on bct_pkg for the entry word type.
`timescale 1ns / 1ps

module bct_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       addr,
   input  bct_pkg::entry_type  wdata,
   output bct_pkg::entry_type  rdata
);
   import bct_pkg::*;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/bct_cmp.sv
// Shared entry compare unit: key match for searches, free-slot test for append.
// Depends on bct_pkg for opcodes and the entry word type.
`timescale 1ns / 1ps

module bct_cmp (
   input  bct_pkg::op_type    op,
   input  bct_pkg::entry_type word,
   input  logic [7:0]         key,
   input  logic               use_valid,
   output logic               hit
);
   import bct_pkg::*;

   always_comb begin
      if (op == OP_APPEND) begin
         hit = !word.vld;
      end else begin
         hit = (!use_valid || word.vld) && (word.val == key);
      end
   end

endmodule

>>> hdl/byte_table_with_valid_bits.sv
// Byte table with per-entry valid bits and first-match search.
// Top level: sequencer and config registers; uses bct_pkg, bct_ram, bct_cmp.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_*): valid/stall. A transaction carries req_type,
//   req_slot, req_value and req_new_value. Response channel (rsp_*): one
//   transaction per request with rsp_data, rsp_position and rsp_status.
//   Config port (csr_*): write-only, taken whenever csr_write is high; write
//   it only while no request is in flight.
// Sequencing (one request at a time):
//   read, write, pop in range: slot read (S_SLOT), commit (S_COMMIT), response (S_FINISH).
//   out-of-range slot, append with valid bits off, nop: straight to S_FINISH.
//   remove, replace, find, append: one table entry per cycle through the
//   single memory port and the shared compare unit, over the first size
//   entries (size = min(entries_in_use, DEPTH)), stopping early on a hit.
// Reset: synchronous, active high. After reset a clearing pass zeroes every
//   word and valid bit; req_stall stays high during it.
// Receiver stall: the response sits in an output register; the request
//   side is freed at once, and a following request finishes only when the
//   output register has been emptied.
module byte_table_with_valid_bits #(
   parameter int DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_type,
   input  logic [7:0] req_slot,
   input  logic [7:0] req_value,
   input  logic [7:0] req_new_value,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data,
   output logic [8:0] rsp_position,
   output logic [2:0] rsp_status,

   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_wdata
);
   import bct_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // counter width: holds DEPTH and any 9-bit register value
   localparam int SW = (AW + 1 > 9) ? AW + 1 : 9;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SLOT   = 6'b000100,
      S_SCAN   = 6'b001000,
      S_COMMIT = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   // config registers
   logic [8:0] entries_ff, entries_in;
   logic [7:0] empty_ff, empty_in;
   logic       usev_ff, usev_in;

   // sequencer
   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   logic [7:0]  key_ff, key_in;
   logic [7:0]  repl_ff, repl_in;
   logic [SW-1:0] issue_ff, issue_in;
   logic [SW-1:0] chk_ff, chk_in;
   logic        chk_vld_ff, chk_vld_in;
   logic [SW-1:0] tgt_ff, tgt_in;
   entry_type   word_ff, word_in;
   logic [7:0]  res_data_ff, res_data_in;
   logic [8:0]  res_pos_ff, res_pos_in;
   logic [2:0]  res_status_ff, res_status_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [8:0]  rsp_pos_ff, rsp_pos_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;

   logic [SW-1:0] size;
   logic          accept;
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   entry_type     ram_wdata;
   entry_type     ram_q;
   logic          cmp_hit;

   assign size = (SW'(entries_ff) > SW'(DEPTH)) ? SW'(DEPTH) : SW'(entries_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;

   bct_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_q)
   );

   bct_cmp u_cmp (
      .op        (op_ff),
      .word      (ram_q),
      .key       (key_ff),
      .use_valid (usev_ff),
      .hit       (cmp_hit)
   );

   // config writes
   always_comb begin
      entries_in = entries_ff;
      empty_in   = empty_ff;
      usev_in    = usev_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ENTRIES:   entries_in = csr_wdata;
            CSR_EMPTY:     empty_in   = csr_wdata[7:0];
            CSR_USE_VALID: usev_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      repl_in       = repl_ff;
      issue_in      = issue_ff;
      chk_in        = chk_ff;
      chk_vld_in    = chk_vld_ff;
      tgt_in        = tgt_ff;
      word_in       = word_ff;
      res_data_in   = res_data_ff;
      res_pos_in    = res_pos_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_addr      = AW'(issue_ff);
      ram_wdata     = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (issue_ff == SW'(DEPTH - 1)) begin
               issue_in = '0;
               state_in = S_IDLE;
            end else begin
               issue_in = issue_ff + 1'b1;
            end
         end

         S_IDLE: begin
            ram_addr = AW'(req_slot);
            if (accept) begin
               op_in         = op_type'(req_type);
               key_in        = req_value;
               repl_in       = req_new_value;
               issue_in      = '0;
               chk_vld_in    = 1'b0;
               tgt_in        = SW'(req_slot);
               res_data_in   = empty_ff;
               res_pos_in    = 9'(size);
               res_status_in = ST_OK;
               case (op_type'(req_type))
                  OP_READ, OP_WRITE, OP_POP: begin
                     if (SW'(req_slot) >= size) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_SLOT;
                     end
                  end
                  OP_APPEND: begin
                     if (!usev_ff) begin
                        res_status_in = ST_NOVALID;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_REMOVE, OP_REPLACE, OP_FIND: state_in = S_SCAN;
                  default: state_in = S_FINISH;
               endcase
            end
         end

         S_SLOT: begin
            word_in  = ram_q;
            state_in = S_COMMIT;
         end

         // one read issued per cycle; compare checks the registered read data of the last issued read
         S_SCAN: begin
            if (chk_vld_ff && cmp_hit) begin
               tgt_in   = chk_ff;
               word_in  = ram_q;
               state_in = S_COMMIT;
            end else if (issue_ff < size) begin
               chk_in     = issue_ff;
               chk_vld_in = 1'b1;
               issue_in   = issue_ff + 1'b1;
            end else begin
               res_status_in = (op_ff == OP_APPEND) ? ST_FULL : ST_MISS;
               state_in      = S_FINISH;
            end
         end

         S_COMMIT: begin
            ram_addr   = AW'(tgt_ff);
            res_pos_in = 9'(tgt_ff);
            case (op_ff)
               OP_READ: res_data_in = word_ff.val;
               OP_WRITE: begin
                  ram_we    = 1'b1;
                  ram_wdata = '{vld: usev_ff | word_ff.vld, val: key_ff};
               end
               OP_POP: begin
                  res_data_in = word_ff.val;
                  ram_we      = 1'b1;
                  ram_wdata   = '{vld: !usev_ff & word_ff.vld, val: empty_ff};
               end
               OP_APPEND: begin
                  ram_we    = 1'b1;
                  ram_wdata = '{vld: 1'b1, val: key_ff};
               end
               OP_REMOVE: begin
                  ram_we    = 1'b1;
                  ram_wdata = '{vld: !usev_ff & word_ff.vld, val: empty_ff};
               end
               OP_REPLACE: begin
                  ram_we    = 1'b1;
                  ram_wdata = '{vld: word_ff.vld, val: repl_ff};
               end
               default: ;
            endcase
            state_in = S_FINISH;
         end

         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff   <= 9'd256;
         empty_ff     <= 8'd0;
         usev_ff      <= 1'b1;
         state_ff     <= S_CLEAR;
         issue_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         entries_ff   <= entries_in;
         empty_ff     <= empty_in;
         usev_ff      <= usev_in;
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      repl_ff       <= repl_in;
      chk_ff        <= chk_in;
      tgt_ff        <= tgt_in;
      word_ff       <= word_in;
      res_data_ff   <= res_data_in;
      res_pos_ff    <= res_pos_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_status   = rsp_status_ff;

   // a request never completes in the cycle it is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request port free right after accept");

   // commit always targets an entry in use
   a_commit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |-> (tgt_ff < size))
      else $error("commit outside the in-use range");

   // no response while the clearing pass runs
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clearing pass");

   // a scan hit moves straight to commit
   a_hit_commits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && chk_vld_ff && cmp_hit) |=> (state_ff == S_COMMIT))
      else $error("scan hit not committed");

endmodule
